// ----- hw/rtl/pyramid_range_query_decomposer_assert.svh -----
// Assertion helpers for the pyramid range-query decomposer.
`ifndef PYRAMID_RANGE_QUERY_DECOMPOSER_ASSERT_SVH
`define PYRAMID_RANGE_QUERY_DECOMPOSER_ASSERT_SVH

// Consequent checked in the same cycle.
`define PRQD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle.
`define PRQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/prqd_pkg.sv -----
package prqd_pkg;

  localparam int StoreDepth      = 16;
  localparam int AddrW           = 4;
  localparam int CntW            = 5;
  localparam int IdxW            = 5;
  localparam int CoordW          = 18;
  localparam int HeightW         = 16;
  localparam int StatusW         = 2;
  localparam int MaxDimDefault   = 16;
  localparam int FracBitsDefault = 16;

  typedef enum logic [StatusW-1:0] {
    StRange       = 2'd0,
    StNoRanges    = 2'd1,
    StBadInterval = 2'd2,
    StTooMany     = 2'd3
  } status_e;

endpackage

// ----- hw/rtl/prqd_ram.sv -----
module prqd_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = prqd_pkg::StoreDepth
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/pyramid_range_query_decomposer.sv -----
// Pyramid range-query decomposer.
// A query box arrives one dimension per request: lo_coord_i/hi_coord_i in signed
// fixed point (FRAC_BITS fraction bits), last_dim_i on the final dimension. A
// request is taken at a rising edge with start_i high and busy_o low.
// Dimensions that are not the last are taken one per cycle and give no result.
// On the last dimension, if an interval was inverted, too many dimensions came
// or none were stored, a single status result appears in the next cycle and the
// block stays ready. Otherwise busy_o stays high while one pyramid per cycle
// is read from the dimension store (one read port, registered read data),
// and each surviving pyramid's height interval is sent once the next survivor
// or the end of the scan is known, so the final result (last_result_o set)
// comes in the first cycle in which busy_o is low again.
// Results are single-cycle strobes on result_valid_o; the receiver cannot stall.
// Reset clears the query state; store contents are undefined until written.
module pyramid_range_query_decomposer #(
  parameter int MAX_DIM   = prqd_pkg::MaxDimDefault,
  parameter int FRAC_BITS = prqd_pkg::FracBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [prqd_pkg::CoordW-1:0]   lo_coord_i,
  input  logic signed [prqd_pkg::CoordW-1:0]   hi_coord_i,
  input  logic                                 last_dim_i,
  output logic                                 result_valid_o,
  output logic        [prqd_pkg::IdxW-1:0]     pyr_id_o,
  output logic        [prqd_pkg::HeightW-1:0]  height_lo_o,
  output logic        [prqd_pkg::HeightW-1:0]  height_hi_o,
  output logic        [prqd_pkg::StatusW-1:0]  status_o,
  output logic                                 last_result_o
);

  `include "pyramid_range_query_decomposer_assert.svh"

  localparam int AddrW    = prqd_pkg::AddrW;
  localparam int CntW     = prqd_pkg::CntW;
  localparam int IdxW     = prqd_pkg::IdxW;
  localparam int HeightW  = prqd_pkg::HeightW;
  localparam int CW       = (FRAC_BITS >= 18) ? FRAC_BITS + 1 : 19;
  localparam int EW       = CW + 1;
  localparam int DimLimit = (MAX_DIM < prqd_pkg::StoreDepth) ? MAX_DIM : prqd_pkg::StoreDepth;
  localparam logic signed [EW-1:0] Half = EW'(64'd1 << (FRAC_BITS - 1));

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SScan  = 2'd1;
  localparam logic [1:0] STail  = 2'd2;
  localparam logic [1:0] SFinal = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  dims_q, dims_d;
  logic [CW-1:0]    best_q, best_d;
  logic [CW-1:0]    second_q, second_d;
  logic [AddrW-1:0] best_dim_q, best_dim_d;
  logic             bad_q, bad_d;
  logic             ovf_q, ovf_d;

  logic [AddrW-1:0] dim_q, dim_d;
  logic             side_q, side_d;
  logic [IdxW-1:0]  p_q, p_d;

  logic             s2_valid_q, s2_valid_d;
  logic [AddrW-1:0] s2_dim_q, s2_dim_d;
  logic             s2_side_q, s2_side_d;
  logic [IdxW-1:0]  s2_p_q, s2_p_d;

  logic               pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]    pend_p_q, pend_p_d;
  logic [HeightW-1:0] pend_hlo_q, pend_hlo_d;
  logic [HeightW-1:0] pend_hhi_q, pend_hhi_d;

  logic               out_valid_q, out_valid_d;
  logic [IdxW-1:0]    out_p_q, out_p_d;
  logic [HeightW-1:0] out_hlo_q, out_hlo_d;
  logic [HeightW-1:0] out_hhi_q, out_hhi_d;
  prqd_pkg::status_e  out_st_q, out_st_d;
  logic               out_last_q, out_last_d;

  logic               accept;
  logic               ram_we;
  logic               ram_re;
  logic [2*CW-1:0]    ram_wdata;
  logic [2*CW-1:0]    ram_rdata;

  logic signed [EW-1:0] ld_cl, ld_ch, ld_abs_l, ld_abs_h, ld_r;
  logic                 ld_bad, ld_full;
  logic [AddrW-1:0]     last_idx;

  logic signed [EW-1:0] s2_cl, s2_ch, s2_blo, s2_bhi, s2_other, s2_hlo, s2_hhi;
  logic                 s2_hit;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != SIdle);

  assign ld_cl    = EW'(lo_coord_i) - Half;
  assign ld_ch    = EW'(hi_coord_i) - Half;
  assign ld_abs_l = (ld_cl < 0) ? -ld_cl : ld_cl;
  assign ld_abs_h = (ld_ch < 0) ? -ld_ch : ld_ch;
  assign ld_r     = (ld_cl <= 0 && ld_ch >= 0) ? '0 :
                    ((ld_abs_l < ld_abs_h) ? ld_abs_l : ld_abs_h);
  assign ld_bad   = lo_coord_i > hi_coord_i;
  assign ld_full  = dims_q >= CntW'(DimLimit);
  assign last_idx = AddrW'(dims_q - CntW'(1));

  assign ram_wdata = {ld_cl[CW-1:0], ld_ch[CW-1:0]};

  prqd_ram #(
    .WIDTH (2 * CW),
    .DEPTH (prqd_pkg::StoreDepth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (dims_q[AddrW-1:0]),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (dim_q),
    .rd_data_o (ram_rdata)
  );

  // Height interval of the pyramid read last cycle.
  always_comb begin
    s2_cl    = EW'($signed(ram_rdata[2*CW-1:CW]));
    s2_ch    = EW'($signed(ram_rdata[CW-1:0]));
    if (s2_side_q) begin
      s2_blo = (s2_cl > 0) ? s2_cl : '0;
      s2_bhi = s2_ch;
    end else begin
      s2_blo = (-s2_ch > 0) ? -s2_ch : '0;
      s2_bhi = -s2_cl;
    end
    s2_other = (s2_dim_q == best_dim_q) ? {1'b0, second_q} : {1'b0, best_q};
    s2_hlo   = (s2_blo > s2_other) ? s2_blo : s2_other;
    s2_hhi   = (s2_bhi < Half) ? s2_bhi : Half;
    s2_hit   = (s2_blo <= s2_bhi) && (s2_hlo <= s2_hhi);
  end

  always_comb begin
    state_d      = state_q;
    dims_d       = dims_q;
    best_d       = best_q;
    second_d     = second_q;
    best_dim_d   = best_dim_q;
    bad_d        = bad_q;
    ovf_d        = ovf_q;
    dim_d        = dim_q;
    side_d       = side_q;
    p_d          = p_q;
    s2_valid_d   = 1'b0;
    s2_dim_d     = s2_dim_q;
    s2_side_d    = s2_side_q;
    s2_p_d       = s2_p_q;
    pend_valid_d = pend_valid_q;
    pend_p_d     = pend_p_q;
    pend_hlo_d   = pend_hlo_q;
    pend_hhi_d   = pend_hhi_q;
    out_valid_d  = 1'b0;
    out_p_d      = out_p_q;
    out_hlo_d    = out_hlo_q;
    out_hhi_d    = out_hhi_q;
    out_st_d     = out_st_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (s2_valid_q && s2_hit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_p_d     = pend_p_q;
        out_hlo_d   = pend_hlo_q;
        out_hhi_d   = pend_hhi_q;
        out_st_d    = prqd_pkg::StRange;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_p_d     = s2_p_q;
      pend_hlo_d   = s2_hlo[HeightW-1:0];
      pend_hhi_d   = s2_hhi[HeightW-1:0];
    end

    case (state_q)
      SIdle: begin
        if (accept) begin
          if (ld_bad) begin
            bad_d = 1'b1;
          end else if (ld_full) begin
            ovf_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            if (ld_r[CW-1:0] > best_q) begin
              second_d   = best_q;
              best_d     = ld_r[CW-1:0];
              best_dim_d = dims_q[AddrW-1:0];
            end else if (ld_r[CW-1:0] > second_q) begin
              second_d = ld_r[CW-1:0];
            end
            dims_d = dims_q + CntW'(1);
          end
          if (last_dim_i) begin
            if (bad_d || ovf_d || (dims_d == '0)) begin
              out_valid_d = 1'b1;
              out_p_d     = '0;
              out_hlo_d   = '0;
              out_hhi_d   = '0;
              out_last_d  = 1'b1;
              out_st_d    = bad_d ? prqd_pkg::StBadInterval :
                            (ovf_d ? prqd_pkg::StTooMany : prqd_pkg::StNoRanges);
              dims_d      = '0;
              best_d      = '0;
              second_d    = '0;
              best_dim_d  = '0;
              bad_d       = 1'b0;
              ovf_d       = 1'b0;
            end else begin
              state_d = SScan;
              dim_d   = '0;
              side_d  = 1'b0;
              p_d     = '0;
            end
          end
        end
      end
      SScan: begin
        ram_re     = 1'b1;
        s2_valid_d = 1'b1;
        s2_dim_d   = dim_q;
        s2_side_d  = side_q;
        s2_p_d     = p_q;
        p_d        = p_q + IdxW'(1);
        if (dim_q == last_idx) begin
          dim_d  = '0;
          side_d = 1'b1;
          if (side_q) begin
            state_d = STail;
          end
        end else begin
          dim_d = dim_q + AddrW'(1);
        end
      end
      STail: begin
        state_d = SFinal;
      end
      SFinal: begin
        out_valid_d  = 1'b1;
        out_last_d   = 1'b1;
        if (pend_valid_q) begin
          out_p_d   = pend_p_q;
          out_hlo_d = pend_hlo_q;
          out_hhi_d = pend_hhi_q;
          out_st_d  = prqd_pkg::StRange;
        end else begin
          out_p_d   = '0;
          out_hlo_d = '0;
          out_hhi_d = '0;
          out_st_d  = prqd_pkg::StNoRanges;
        end
        pend_valid_d = 1'b0;
        dims_d       = '0;
        best_d       = '0;
        second_d     = '0;
        best_dim_d   = '0;
        bad_d        = 1'b0;
        ovf_d        = 1'b0;
        state_d      = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      dims_q       <= '0;
      best_q       <= '0;
      second_q     <= '0;
      best_dim_q   <= '0;
      bad_q        <= 1'b0;
      ovf_q        <= 1'b0;
      dim_q        <= '0;
      side_q       <= 1'b0;
      p_q          <= '0;
      s2_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      dims_q       <= dims_d;
      best_q       <= best_d;
      second_q     <= second_d;
      best_dim_q   <= best_dim_d;
      bad_q        <= bad_d;
      ovf_q        <= ovf_d;
      dim_q        <= dim_d;
      side_q       <= side_d;
      p_q          <= p_d;
      s2_valid_q   <= s2_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_dim_q   <= s2_dim_d;
    s2_side_q  <= s2_side_d;
    s2_p_q     <= s2_p_d;
    pend_p_q   <= pend_p_d;
    pend_hlo_q <= pend_hlo_d;
    pend_hhi_q <= pend_hhi_d;
    out_p_q    <= out_p_d;
    out_hlo_q  <= out_hlo_d;
    out_hhi_q  <= out_hhi_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
  end

  assign result_valid_o  = out_valid_q;
  assign pyr_id_o        = out_p_q;
  assign height_lo_o     = out_hlo_q;
  assign height_hi_o     = out_hhi_q;
  assign status_o        = out_st_q;
  assign last_result_o   = out_last_q;

  `PRQD_ASSERT_NOW(a_status_is_last, clk_i, rst_ni,
    result_valid_o && (status_o != prqd_pkg::StRange), last_result_o, "status result not last")
  `PRQD_ASSERT_NOW(a_range_ordered, clk_i, rst_ni,
    result_valid_o && (status_o == prqd_pkg::StRange), height_lo_o <= height_hi_o,
    "height interval inverted")
  `PRQD_ASSERT_NOW(a_mid_result_busy, clk_i, rst_ni,
    result_valid_o && !last_result_o, busy_o, "non-final result outside a scan")
  `PRQD_ASSERT_NOW(a_scan_in_range, clk_i, rst_ni,
    state_q == SScan, CntW'(dim_q) < dims_q, "scan index beyond stored dimensions")
  `PRQD_ASSERT_NEXT(a_final_returns, clk_i, rst_ni,
    state_q == SFinal, (state_q == SIdle) && result_valid_o && last_result_o,
    "final result missing")

endmodule
